/* design/ssfc_pkg.sv */
// Shared constants for the sorted set floor and ceiling query unit.
`default_nettype none

package ssfc_pkg;

  // Payload widths
  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW  = 2;

  // Request codes
  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_QUERY  = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

/* design/sorted_set_floor_ceiling_query_unit.sv */
// Sorted value table with insert, clear and floor/ceiling query, held in one RAM.
// One request at a time: after the accept, a binary search over the entries reads the RAM,
// an insert then moves each larger entry up one slot and writes the key, and a query reads
// the floor and ceiling entries. Clear, a full-table insert and an unused code go straight
// to the output load. Throughput: the next request is accepted while the output register
// holds a result until taken.
// Reset zeroes the entry count; RAM contents are not cleared and there is no clearing pass.
`default_nettype none

module sorted_set_floor_ceiling_query_unit
  import ssfc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ReqW-1:0]  req_type_i,
  input  wire logic [DataW-1:0] value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  status_o,
  output logic                  floor_found_o,
  output logic      [DataW-1:0] floor_value_o,
  output logic                  ceil_found_o,
  output logic      [DataW-1:0] ceil_value_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_SH_RD,
    S_SH_WR,
    S_Q_FLOOR,
    S_Q_CEIL,
    S_Q_DONE,
    S_REPLY
  } state_e;

  typedef enum logic [1:0] {
    RPL_ZERO,
    RPL_FULL,
    RPL_QUERY
  } reply_e;

  state_e           state_q;
  reply_e           reply_q;
  logic             is_insert_q;
  logic [DataW-1:0] key_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  lo_q;
  logic [CntW-1:0]  hi_q;
  logic [CntW-1:0]  k_q;
  logic [DataW-1:0] floor_q;
  logic [DataW-1:0] ceil_q;
  logic             out_valid_q;
  logic             status_q;
  logic             floor_found_q;
  logic [DataW-1:0] floor_value_q;
  logic             ceil_found_q;
  logic [DataW-1:0] ceil_value_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic [CntW:0]    mid_sum;
  logic [CntW-1:0]  mid;
  logic [CntW-1:0]  lo_m1;
  logic [CntW-1:0]  k_m1;
  logic             in_xfer;
  logic             out_free;
  logic             fl_found;
  logic             fl_equal;
  logic             ce_below_cnt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Search midpoint and decremented indexes
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CntW:1];
  assign lo_m1   = lo_q - CntOne;
  assign k_m1    = k_q - CntOne;

  // Query result terms; lo_q holds the count of entries at most the key
  assign fl_found     = (lo_q != '0);
  assign fl_equal     = fl_found && (floor_q == key_q);
  assign ce_below_cnt = (lo_q < count_q);

  // Drive RAM ports from the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid[AddrW-1:0];
        end
      end
      S_SH_RD: begin
        if (k_q > lo_q) begin
          ram_re    = 1'b1;
          ram_raddr = k_m1[AddrW-1:0];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = lo_q[AddrW-1:0];
          ram_wdata = key_q;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AddrW-1:0];
        ram_wdata = ram_rdata;
      end
      S_Q_FLOOR: begin
        ram_re = fl_found;
        if (fl_found) begin
          ram_raddr = lo_m1[AddrW-1:0];
        end
      end
      S_Q_CEIL: begin
        ram_re = ce_below_cnt;
        if (ce_below_cnt) begin
          ram_raddr = lo_q[AddrW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  ssfc_ram #(
    .Width(DataW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequence requests and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      reply_q       <= RPL_ZERO;
      is_insert_q   <= 1'b0;
      key_q         <= '0;
      count_q       <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      k_q           <= '0;
      floor_q       <= '0;
      ceil_q        <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= STATUS_OK;
      floor_found_q <= 1'b0;
      floor_value_q <= '0;
      ceil_found_q  <= 1'b0;
      ceil_value_q  <= '0;
    end else begin
      // Drop the result once it is taken, unless a new one loads in its place
      if (out_valid_q && out_ready_i && (state_q != S_REPLY)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            key_q <= value_i;
            lo_q  <= '0;
            hi_q  <= count_q;
            case (req_type_i)
              REQ_INSERT: begin
                is_insert_q <= 1'b1;
                if (count_q == CntFull) begin
                  reply_q <= RPL_FULL;
                  state_q <= S_REPLY;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              REQ_QUERY: begin
                is_insert_q <= 1'b0;
                state_q     <= S_SRCH;
              end
              REQ_CLEAR: begin
                count_q <= '0;
                reply_q <= RPL_ZERO;
                state_q <= S_REPLY;
              end
              default: begin
                reply_q <= RPL_ZERO;
                state_q <= S_REPLY;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo_q < hi_q) begin
            state_q <= S_CMP;
          end else if (is_insert_q) begin
            k_q     <= count_q;
            state_q <= S_SH_RD;
          end else begin
            state_q <= S_Q_FLOOR;
          end
        end
        S_CMP: begin
          // Narrow toward the first entry above the key
          if (ram_rdata <= key_q) begin
            lo_q <= mid + CntOne;
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_SH_RD: begin
          if (k_q > lo_q) begin
            state_q <= S_SH_WR;
          end else begin
            count_q <= count_q + CntOne;
            reply_q <= RPL_ZERO;
            state_q <= S_REPLY;
          end
        end
        S_SH_WR: begin
          k_q     <= k_m1;
          state_q <= S_SH_RD;
        end
        S_Q_FLOOR: begin
          state_q <= S_Q_CEIL;
        end
        S_Q_CEIL: begin
          floor_q <= ram_rdata;
          state_q <= S_Q_DONE;
        end
        S_Q_DONE: begin
          ceil_q  <= ram_rdata;
          reply_q <= RPL_QUERY;
          state_q <= S_REPLY;
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            status_q      <= (reply_q == RPL_FULL) ? STATUS_FULL : STATUS_OK;
            floor_found_q <= (reply_q == RPL_QUERY) && fl_found;
            floor_value_q <= ((reply_q == RPL_QUERY) && fl_found) ? floor_q : '0;
            ceil_found_q  <= (reply_q == RPL_QUERY) && (fl_equal || ce_below_cnt);
            if (reply_q != RPL_QUERY) begin
              ceil_value_q <= '0;
            end else if (fl_equal) begin
              ceil_value_q <= key_q;
            end else if (ce_below_cnt) begin
              ceil_value_q <= ceil_q;
            end else begin
              ceil_value_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign floor_found_o = floor_found_q;
  assign floor_value_o = floor_value_q;
  assign ceil_found_o  = ceil_found_q;
  assign ceil_value_o  = ceil_value_q;

  // Entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count exceeds table depth");

  // A transfer in closes the input until the request finishes
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input open while a request is in progress");

  // Writes land inside the occupied part of the table or its next slot
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CntW'(ram_waddr) <= count_q) && (count_q != CntFull))
    else $error("table write outside the filled range");

  // Search window stays ordered and within the count
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH || state_q == S_CMP) |-> (lo_q <= hi_q) && (hi_q <= count_q))
    else $error("search window out of order");

endmodule

`default_nettype wire

/* design/ssfc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ssfc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sim/ssfc_result_checker.sv */
// Checker that predicts and compares every result of the sorted set floor and ceiling query unit.
module ssfc_result_checker
  import ssfc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int          REPORT_MAX  = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ReqW-1:0]  req_type_i,
  input  logic [DataW-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             status_i,
  input  logic             floor_found_i,
  input  logic [DataW-1:0] floor_value_i,
  input  logic             ceil_found_i,
  input  logic [DataW-1:0] ceil_value_i,
  output int               error_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic             status;
    logic             floor_found;
    logic [DataW-1:0] floor_value;
    logic             ceil_found;
    logic [DataW-1:0] ceil_value;
  } query_result_t;

  // Sorted copy of the table and the results still owed by the block
  logic [DataW-1:0] sorted_values[$];
  query_result_t    due_results[$];
  int               mismatches = 0;

  assign error_count_o = mismatches;

  // Apply one request to the table copy and return the result it earns
  function automatic query_result_t apply_request(input logic [ReqW-1:0] req,
                                                  input logic [DataW-1:0] key);
    query_result_t res;
    int unsigned   at_most;
    int unsigned   below;
    int            k;
    res     = '0;
    at_most = 0;
    below   = 0;
    foreach (sorted_values[i]) begin
      if (sorted_values[i] <= key) at_most++;
      if (sorted_values[i] < key) below++;
    end
    case (req)
      REQ_INSERT: begin
        if (sorted_values.size() >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          // Place the key after every entry at most its value
          sorted_values = {sorted_values, key};
          for (k = sorted_values.size() - 1; k > int'(at_most); k--) begin
            sorted_values[k] = sorted_values[k-1];
          end
          sorted_values[at_most] = key;
        end
      end
      REQ_QUERY: begin
        if (at_most > 0) begin
          res.floor_found = 1'b1;
          res.floor_value = sorted_values[at_most-1];
        end
        if (below < sorted_values.size()) begin
          res.ceil_found = 1'b1;
          res.ceil_value = sorted_values[below];
        end
      end
      REQ_CLEAR: begin
        sorted_values.delete();
      end
      default: begin
        // Unused code: table untouched, all-zero result
      end
    endcase
    return res;
  endfunction

  // Track transfers on both channels and compare against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    query_result_t seen;
    query_result_t want;
    if (!rst_ni) begin
      sorted_values.delete();
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        due_results = {due_results, apply_request(req_type_i, value_i)};
      end
      if (out_valid_i && out_ready_i) begin
        seen = {status_i, floor_found_i, floor_value_i, ceil_found_i, ceil_value_i};
        if (due_results.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: result with nothing pending: status %0d floor %0d/%0h ceil %0d/%0h",
                     $realtime, seen.status, seen.floor_found, seen.floor_value,
                     seen.ceil_found, seen.ceil_value);
          end
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: mismatch: expected status %0d floor %0d/%0h ceil %0d/%0h",
                       $realtime, want.status, want.floor_found, want.floor_value,
                       want.ceil_found, want.ceil_value);
              $display("%0t:           actual   status %0d floor %0d/%0h ceil %0d/%0h",
                       $realtime, seen.status, seen.floor_found, seen.floor_value,
                       seen.ceil_found, seen.ceil_value);
            end
            mismatches++;
          end
        end
      end
      pending_o <= due_results.size();
    end
  end

endmodule

/* sim/tb.sv */
// Top of the testbench: stimulus, receiver stalls and verdict for the query unit.
module tb;
  import ssfc_pkg::*;

  localparam int unsigned      TABLE_DEPTH  = 256;
  localparam logic [ReqW-1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [DataW-1:0] MAX_VALUE    = '1;
  localparam int               RANDOM_ITEMS = 90;
  localparam int               DRAIN_CYCLES = 600;
  localparam int               CYCLE_LIMIT  = 2000000;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [ReqW-1:0]  req_type_i  = REQ_INSERT;
  logic [DataW-1:0] value_i     = '0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic             status_o;
  logic             floor_found_o;
  logic [DataW-1:0] floor_value_o;
  logic             ceil_found_o;
  logic [DataW-1:0] ceil_value_o;

  int       error_count;
  int       pending;
  int       cycle_count  = 0;
  int       burst_left   = 0;
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold      = 0;

  sorted_set_floor_ceiling_query_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .floor_found_o(floor_found_o),
    .floor_value_o(floor_value_o),
    .ceil_found_o (ceil_found_o),
    .ceil_value_o (ceil_value_o)
  );

  ssfc_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .floor_found_i(floor_found_o),
    .floor_value_i(floor_value_o),
    .ceil_found_i (ceil_found_o),
    .ceil_value_i (ceil_value_o),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: switch between always ready, choppy and long stalls
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(30, 300);
      rx_hold      = 0;
    end
    rx_mode_left--;
    if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          out_ready_i <= 1'b1;
        end
        RX_CHOPPY: begin
          out_ready_i <= $urandom_range(0, 1);
          rx_hold = $urandom_range(0, 2);
        end
        default: begin
          if (out_ready_i) begin
            out_ready_i <= 1'b0;
            rx_hold = $urandom_range(4, 20);
          end else begin
            out_ready_i <= 1'b1;
            rx_hold = $urandom_range(0, 3);
          end
        end
      endcase
    end
  end

  // Keys: mostly a small pool so that duplicates and exact hits are common
  function automatic logic [DataW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      7:       return '0;
      8:       return MAX_VALUE;
      9:       return MAX_VALUE - $urandom_range(0, 31);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // Offer one request and hold it until the transfer; gaps fall between bursts
  task automatic send_request(input logic [ReqW-1:0] req, input logic [DataW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Stop sending until every owed result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random mix of requests at random keys
  task automatic send_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_request(REQ_INSERT, pick_key());
      else if (pick < 88) send_request(REQ_QUERY, pick_key());
      else if (pick < 94) send_request(REQ_CLEAR, pick_key());
      else send_request(REQ_UNUSED, pick_key());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, single entry, extremes, duplicates and the unused code
    send_request(REQ_QUERY, '0);
    send_request(REQ_QUERY, MAX_VALUE);
    send_request(REQ_INSERT, 32'd100);
    send_request(REQ_QUERY, 32'd100);
    send_request(REQ_QUERY, 32'd99);
    send_request(REQ_QUERY, 32'd101);
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, MAX_VALUE);
    send_request(REQ_INSERT, 32'd100);
    send_request(REQ_QUERY, '0);
    send_request(REQ_QUERY, MAX_VALUE);
    send_request(REQ_QUERY, 32'd50);
    send_request(REQ_QUERY, 32'd100);
    send_request(REQ_UNUSED, MAX_VALUE);
    send_request(REQ_QUERY, 32'hAAAA_5555);
    send_request(REQ_CLEAR, MAX_VALUE);
    send_request(REQ_QUERY, 32'd100);
    send_request(REQ_INSERT, MAX_VALUE);
    send_request(REQ_QUERY, MAX_VALUE - 1);
    send_request(REQ_QUERY, MAX_VALUE);
    wait_drained();

    send_random(RANDOM_ITEMS);
    wait_drained();

    // Fill the table to its depth, then push inserts that must be dropped
    send_request(REQ_CLEAR, '0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_request(REQ_INSERT, pick_key());
      if (i % 16 == 15) send_request(REQ_QUERY, pick_key());
    end
    for (int i = 0; i < 4; i++) begin
      send_request(REQ_INSERT, pick_key());
      send_request(REQ_QUERY, (i % 2 == 0) ? MAX_VALUE : '0);
    end
    wait_drained();
    send_request(REQ_QUERY, pick_key());
    send_request(REQ_CLEAR, pick_key());

    send_random(RANDOM_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ssfc_pkg.sv
design/ssfc_ram.sv
design/sorted_set_floor_ceiling_query_unit.sv
sim/ssfc_result_checker.sv
sim/tb.sv
